[src/rkp_pkg.sv]
package rkp_pkg;

  localparam int OP_W = 64;
  localparam int DV_W = 62;
  localparam int Q_W  = 58;

  // Saturation bound of the 60-bit signed quantities and of saturated quotients.
  localparam logic [63:0] WCAP = (64'd1 << 58) - 64'd1;

  typedef logic signed [59:0] sw_t;
  typedef logic signed [63:0] sl_t;

  typedef struct packed {
    logic              go;
    logic [OP_W-1:0]   a;
    logic [OP_W-1:0]   b;
    logic [DV_W-1:0]   d;
  } md_req_t;

  typedef struct packed {
    logic              done;
    logic [Q_W-1:0]    q;
  } md_rsp_t;

  // Configuration register indexes.
  localparam logic [2:0] CFG_RATE1 = 3'd0;
  localparam logic [2:0] CFG_RATE2 = 3'd1;
  localparam logic [2:0] CFG_RATE3 = 3'd2;
  localparam logic [2:0] CFG_FEEDA = 3'd3;
  localparam logic [2:0] CFG_FEEDB = 3'd4;
  localparam logic [2:0] CFG_DRAW  = 3'd5;
  localparam logic [2:0] CFG_PURGE = 3'd6;

  // Derivative operations, in issue order.
  localparam logic [3:0] D_T1  = 4'd0;
  localparam logic [3:0] D_R1  = 4'd1;
  localparam logic [3:0] D_T2  = 4'd2;
  localparam logic [3:0] D_R2  = 4'd3;
  localparam logic [3:0] D_T3  = 4'd4;
  localparam logic [3:0] D_R3  = 4'd5;
  localparam logic [3:0] D_P0  = 4'd6;
  localparam logic [3:0] D_P1  = 4'd7;
  localparam logic [3:0] D_P2  = 4'd8;
  localparam logic [3:0] D_P3  = 4'd9;
  localparam logic [3:0] D_Q   = 4'd10;
  localparam logic [3:0] D_Q10 = 4'd11;
  localparam logic [3:0] D_P4  = 4'd12;
  localparam logic [3:0] D_P5  = 4'd13;
  localparam int         D_NUM = 14;

  // Output flow operations.
  localparam logic [1:0] F_FTP = 2'd0;
  localparam logic [1:0] F_FTE = 2'd1;
  localparam logic [1:0] F_TEN = 2'd2;
  localparam logic [1:0] F_WF  = 2'd3;

  function automatic sw_t sat60(input sl_t x);
    if (x > sl_t'(WCAP)) begin
      return sw_t'(WCAP);
    end else if (x < -sl_t'(WCAP)) begin
      return -sw_t'(WCAP);
    end
    return sw_t'(x);
  endfunction

  function automatic logic [63:0] mag(input sl_t x);
    return (x < 0) ? 64'(-x) : 64'(x);
  endfunction

  // Halving that truncates toward zero.
  function automatic sl_t half(input sl_t x);
    return (x < 0) ? -sl_t'(mag(x) >> 1) : (x >>> 1);
  endfunction

endpackage

[src/rkp_muldiv.sv]
module rkp_muldiv (
  input  logic             clk,
  input  logic             rst_n,
  input  rkp_pkg::md_req_t req,
  output rkp_pkg::md_rsp_t rsp
);
  import rkp_pkg::*;

  typedef enum logic [4:0] {
    MD_IDLE = 5'b00001,
    MD_MUL  = 5'b00010,
    MD_CHK  = 5'b00100,
    MD_DIV  = 5'b01000,
    MD_DONE = 5'b10000
  } md_state_t;

  md_state_t         state_r, state_nxt;
  logic [OP_W-1:0]   a_r, a_nxt, b_r, b_nxt;
  logic [DV_W-1:0]   d_r, d_nxt;
  logic [127:0]      prod_r, prod_nxt;
  logic [1:0]        j_r, j_nxt;
  logic [5:0]        cnt_r, cnt_nxt;
  logic [DV_W-1:0]   rem_r, rem_nxt;
  logic [Q_W-1:0]    lo_r, lo_nxt;
  logic [Q_W-1:0]    q_r, q_nxt;
  logic              sat_r, sat_nxt;

  logic [31:0]       ah, bh;
  logic [63:0]       pp;
  logic [6:0]        shamt;
  logic [DV_W:0]     trial;

  always_comb begin
    ah    = j_r[1] ? a_r[63:32] : a_r[31:0];
    bh    = j_r[0] ? b_r[63:32] : b_r[31:0];
    pp    = 64'(ah) * 64'(bh);
    shamt = 7'(({1'b0, j_r[1]} + {1'b0, j_r[0]})) << 5;
    trial = {rem_r, lo_r[Q_W-1]};
  end

  always_comb begin
    state_nxt = state_r;
    a_nxt     = a_r;
    b_nxt     = b_r;
    d_nxt     = d_r;
    prod_nxt  = prod_r;
    j_nxt     = j_r;
    cnt_nxt   = cnt_r;
    rem_nxt   = rem_r;
    lo_nxt    = lo_r;
    q_nxt     = q_r;
    sat_nxt   = sat_r;
    unique case (state_r)
      MD_IDLE: begin
        if (req.go) begin
          a_nxt     = req.a;
          b_nxt     = req.b;
          d_nxt     = req.d;
          prod_nxt  = '0;
          j_nxt     = '0;
          state_nxt = MD_MUL;
        end
      end
      MD_MUL: begin
        prod_nxt = prod_r + (128'(pp) << shamt);
        j_nxt    = j_r + 2'd1;
        if (j_r == 2'd3) begin
          state_nxt = MD_CHK;
        end
      end
      MD_CHK: begin
        // A quotient of 2^58 or more saturates, so only 58 bits are developed.
        q_nxt   = '0;
        lo_nxt  = prod_r[Q_W-1:0];
        rem_nxt = prod_r[Q_W+DV_W-1:Q_W];
        cnt_nxt = 6'(Q_W - 1);
        if (prod_r[127:Q_W] >= 70'(d_r)) begin
          sat_nxt   = 1'b1;
          state_nxt = MD_DONE;
        end else begin
          sat_nxt   = 1'b0;
          state_nxt = MD_DIV;
        end
      end
      MD_DIV: begin
        lo_nxt = lo_r << 1;
        if (trial >= (DV_W+1)'(d_r)) begin
          rem_nxt = DV_W'(trial - (DV_W+1)'(d_r));
          q_nxt   = {q_r[Q_W-2:0], 1'b1};
        end else begin
          rem_nxt = DV_W'(trial);
          q_nxt   = {q_r[Q_W-2:0], 1'b0};
        end
        cnt_nxt = cnt_r - 6'd1;
        if (cnt_r == 6'd0) begin
          state_nxt = MD_DONE;
        end
      end
      MD_DONE: begin
        state_nxt = MD_IDLE;
      end
      default: begin
        state_nxt = MD_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= MD_IDLE;
    end else begin
      state_r <= state_nxt;
    end
    a_r    <= a_nxt;
    b_r    <= b_nxt;
    d_r    <= d_nxt;
    prod_r <= prod_nxt;
    j_r    <= j_nxt;
    cnt_r  <= cnt_nxt;
    rem_r  <= rem_nxt;
    lo_r   <= lo_nxt;
    q_r    <= q_nxt;
    sat_r  <= sat_nxt;
  end

  assign rsp.done = (state_r == MD_DONE);
  assign rsp.q    = sat_r ? WCAP[Q_W-1:0] : q_r;

  a_go_idle: assert property (@(posedge clk) disable iff (!rst_n)
    req.go |-> state_r == MD_IDLE) else $error("muldiv started while busy");
  a_rem_lt: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == MD_DIV |-> rem_r < d_r) else $error("partial remainder not below divisor");
  a_done_one: assert property (@(posedge clk) disable iff (!rst_n)
    rsp.done |=> !rsp.done) else $error("done held longer than one cycle");

endmodule

[src/reactor_plant_rk4_step.sv]
// Every quotient goes through one shared multiply-divide unit: four 32x32
// partial products and 58 restoring divide steps per call, 14 calls per
// derivative, 6 per stage update, 4 for the output flows.
// One word is in flight at a time; the result is held until taken.
// Synchronous active-low reset clears the configuration and all six masses.
module reactor_plant_rk4_step #(
  parameter int FRAC_BITS  = 16,
  parameter int MASS_WIDTH = 32
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_we,
  input  logic [2:0]         cfg_index,
  input  logic [31:0]        cfg_wdata,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               in_func,
  input  logic [2:0]         in_species_sel,
  input  logic [31:0]        in_load_mass,
  input  logic [31:0]        in_step_hours,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [31:0]        out_mass_a,
  output logic [31:0]        out_mass_b,
  output logic [31:0]        out_mass_c,
  output logic [31:0]        out_mass_e,
  output logic [31:0]        out_mass_p,
  output logic [31:0]        out_mass_g,
  output logic [34:0]        out_total_mass,
  output logic signed [31:0] out_product_flow,
  output logic [31:0]        out_waste_flow
);
  import rkp_pkg::*;

  localparam int          TOT_W    = MASS_WIDTH + 3;
  localparam logic [63:0] MASS_MAX = (64'd1 << MASS_WIDTH) - 64'd1;
  localparam logic [DV_W-1:0] Q_ONE    = DV_W'(1) << FRAC_BITS;
  localparam logic [DV_W-1:0] HALF_DIV = DV_W'(1) << 33;
  localparam logic [DV_W-1:0] FULL_DIV = DV_W'(1) << 32;
  localparam logic [DV_W-1:0] SIX_DIV  = DV_W'(6) << 32;
  localparam logic [DV_W-1:0] TEN_DIV  = DV_W'(10);
  localparam logic [DV_W-1:0] PURGE_DIV = DV_W'(65536);
  localparam logic [16:0]  PURGE_ONE = 17'd65536;

  typedef enum logic [8:0] {
    ST_IDLE = 9'b000000001,
    ST_EM   = 9'b000000010,
    ST_MT   = 9'b000000100,
    ST_DOP  = 9'b000001000,
    ST_DLAT = 9'b000010000,
    ST_UPD  = 9'b000100000,
    ST_TOT  = 9'b001000000,
    ST_FOP  = 9'b010000000,
    ST_OUT  = 9'b100000000
  } state_t;

  state_t                state_r, state_nxt;
  logic [31:0]           coef1_r, coef2_r, coef3_r, feeda_r, feedb_r, draw_r;
  logic [16:0]           purge_r;
  logic [MASS_WIDTH-1:0] mass_r [6];
  logic [MASS_WIDTH-1:0] mass_nxt [6];
  sw_t                   y_r [6];
  sw_t                   y_nxt [6];
  sw_t                   k_r [6];
  sw_t                   k_nxt [6];
  sl_t                   ks_r [6];
  sl_t                   ks_nxt [6];
  sw_t                   res_r [D_NUM];
  sw_t                   res_nxt [D_NUM];
  logic [Q_W-1:0]        fin_r [4];
  logic [Q_W-1:0]        fin_nxt [4];
  logic [60:0]           mt_r, mt_nxt;
  logic [TOT_W-1:0]      tot_r, tot_nxt;
  logic [31:0]           em_r, em_nxt, rm_r, rm_nxt;
  logic [31:0]           h_r, h_nxt;
  logic [3:0]            cnt_r, cnt_nxt;
  logic [1:0]            stg_r, stg_nxt;
  logic                  wait_r, wait_nxt;

  md_req_t               md_req;
  md_rsp_t               md_rsp;
  logic                  op_neg;
  sl_t                   sres;
  sl_t                   xsel;
  sl_t                   dv [6];
  sl_t                   r1, r2, r3, nv;
  logic [16:0]           eta;

  rkp_muldiv u_md (
    .clk (clk),
    .rst_n (rst_n),
    .req (md_req),
    .rsp (md_rsp)
  );

  always_comb begin
    eta  = (purge_r > PURGE_ONE) ? PURGE_ONE : purge_r;
    xsel = (stg_r == 2'd3) ? ks_r[cnt_r[2:0]] : sl_t'(k_r[cnt_r[2:0]]);
  end

  // Operand selection for the shared unit.
  always_comb begin
    md_req.go = 1'b0;
    md_req.a  = '0;
    md_req.b  = '0;
    md_req.d  = Q_ONE;
    op_neg    = 1'b0;
    unique case (state_r)
      ST_EM: begin
        md_req.a = 64'(eta);
        md_req.b = 64'(draw_r);
        md_req.d = PURGE_DIV;
      end
      ST_DOP: begin
        md_req.d = DV_W'(mt_r);
        unique case (cnt_r)
          D_T1: begin
            md_req.a = mag(sl_t'(y_r[0]));
            md_req.b = mag(sl_t'(y_r[1]));
          end
          D_R1: begin
            md_req.a = 64'(coef1_r);
            md_req.b = 64'(res_r[D_T1]);
            md_req.d = Q_ONE;
            op_neg   = y_r[0][59] ^ y_r[1][59];
          end
          D_T2: begin
            md_req.a = mag(sl_t'(y_r[1]));
            md_req.b = mag(sl_t'(y_r[2]));
          end
          D_R2: begin
            md_req.a = 64'(coef2_r);
            md_req.b = 64'(res_r[D_T2]);
            md_req.d = Q_ONE;
            op_neg   = y_r[1][59] ^ y_r[2][59];
          end
          D_T3: begin
            md_req.a = mag(sl_t'(y_r[2]));
            md_req.b = mag(sl_t'(y_r[4]));
          end
          D_R3: begin
            md_req.a = 64'(coef3_r);
            md_req.b = 64'(res_r[D_T3]);
            md_req.d = Q_ONE;
            op_neg   = y_r[2][59] ^ y_r[4][59];
          end
          D_P0: begin
            md_req.a = mag(sl_t'(y_r[0]));
            md_req.b = 64'(em_r);
            op_neg   = y_r[0][59];
          end
          D_P1: begin
            md_req.a = mag(sl_t'(y_r[1]));
            md_req.b = 64'(em_r);
            op_neg   = y_r[1][59];
          end
          D_P2: begin
            md_req.a = mag(sl_t'(y_r[2]));
            md_req.b = 64'(em_r);
            op_neg   = y_r[2][59];
          end
          D_P3: begin
            md_req.a = mag(sl_t'(y_r[3]));
            md_req.b = 64'(em_r);
            op_neg   = y_r[3][59];
          end
          D_Q: begin
            md_req.a = mag(sl_t'(y_r[3]));
            md_req.b = 64'(rm_r);
            op_neg   = y_r[3][59];
          end
          D_Q10: begin
            md_req.a = mag(sl_t'(res_r[D_Q]));
            md_req.b = 64'd1;
            md_req.d = TEN_DIV;
            op_neg   = res_r[D_Q][59];
          end
          D_P4: begin
            md_req.a = mag(sl_t'(y_r[4]));
            md_req.b = 64'(draw_r);
            op_neg   = y_r[4][59];
          end
          D_P5: begin
            md_req.a = mag(sl_t'(y_r[5]));
            md_req.b = 64'(draw_r);
            op_neg   = y_r[5][59];
          end
          default: begin
            md_req.a = '0;
          end
        endcase
      end
      ST_UPD: begin
        md_req.a = mag(xsel);
        md_req.b = 64'(h_r);
        op_neg   = xsel[63];
        if (stg_r == 2'd3) begin
          md_req.d = SIX_DIV;
        end else if (stg_r == 2'd2) begin
          md_req.d = FULL_DIV;
        end else begin
          md_req.d = HALF_DIV;
        end
      end
      ST_FOP: begin
        md_req.a = 64'(draw_r);
        md_req.d = DV_W'(tot_r);
        unique case (cnt_r[1:0])
          F_FTP: md_req.b = 64'(mass_r[4]);
          F_FTE: md_req.b = 64'(mass_r[3]);
          F_TEN: begin
            md_req.a = 64'(fin_r[F_FTE]);
            md_req.b = 64'd1;
            md_req.d = TEN_DIV;
          end
          F_WF:  md_req.b = 64'(mass_r[5]);
          default: md_req.b = '0;
        endcase
      end
      default: begin
        md_req.a = '0;
      end
    endcase
    if ((state_r == ST_EM || state_r == ST_DOP || state_r == ST_UPD ||
         state_r == ST_FOP) && !wait_r) begin
      md_req.go = 1'b1;
    end
    sres = op_neg ? -sl_t'(md_rsp.q) : sl_t'(md_rsp.q);
  end

  // Derivatives from the collected products and quotients.
  always_comb begin
    r1 = sl_t'(res_r[D_R1]);
    r2 = sl_t'(res_r[D_R2]);
    r3 = sl_t'(res_r[D_R3]);
    dv[0] = sl_t'(feeda_r) - sl_t'(res_r[D_P0]) - r1;
    dv[1] = sl_t'(feedb_r) - sl_t'(res_r[D_P1]) - r1 - r2;
    dv[2] = -sl_t'(res_r[D_P2]) + (r1 <<< 1) - (r2 <<< 1) - r3;
    dv[3] = -sl_t'(res_r[D_P3]) + (r2 <<< 1);
    dv[4] = sl_t'(res_r[D_Q10]) - sl_t'(res_r[D_P4]) + r2 - half(r3);
    dv[5] = -sl_t'(res_r[D_P5]) + r3 + half(r3);
    nv = sl_t'(mass_r[cnt_r[2:0]]) + sres;
  end

  always_comb begin
    state_nxt = state_r;
    mass_nxt  = mass_r;
    y_nxt     = y_r;
    k_nxt     = k_r;
    ks_nxt    = ks_r;
    res_nxt   = res_r;
    fin_nxt   = fin_r;
    mt_nxt    = mt_r;
    tot_nxt   = tot_r;
    em_nxt    = em_r;
    rm_nxt    = rm_r;
    h_nxt     = h_r;
    cnt_nxt   = cnt_r;
    stg_nxt   = stg_r;
    wait_nxt  = wait_r;
    if (md_req.go) begin
      wait_nxt = 1'b1;
    end
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          for (int i = 0; i < 4; i++) begin
            fin_nxt[i] = '0;
          end
          cnt_nxt = '0;
          tot_nxt = '0;
          if (in_func) begin
            if (in_species_sel < 3'd6) begin
              mass_nxt[in_species_sel] = (64'(in_load_mass) > MASS_MAX) ?
                                         MASS_WIDTH'(MASS_MAX) : MASS_WIDTH'(in_load_mass);
            end
            state_nxt = ST_TOT;
          end else begin
            h_nxt   = in_step_hours;
            stg_nxt = '0;
            for (int i = 0; i < 6; i++) begin
              y_nxt[i] = sw_t'({1'b0, mass_r[i]});
            end
            state_nxt = ST_EM;
          end
        end
      end
      ST_EM: begin
        if (md_rsp.done) begin
          wait_nxt  = 1'b0;
          em_nxt    = md_rsp.q[31:0];
          rm_nxt    = draw_r - md_rsp.q[31:0];
          cnt_nxt   = '0;
          mt_nxt    = '0;
          state_nxt = ST_MT;
        end
      end
      ST_MT: begin
        // Only positive stage masses count toward the total.
        if (!y_r[cnt_r[2:0]][59]) begin
          mt_nxt = mt_r + 61'(y_r[cnt_r[2:0]]);
        end
        cnt_nxt = cnt_r + 4'd1;
        if (cnt_r == 4'd5) begin
          cnt_nxt = '0;
          if (mt_nxt == '0) begin
            state_nxt = ST_DLAT;
          end else begin
            state_nxt = ST_DOP;
          end
        end
      end
      ST_DOP: begin
        if (md_rsp.done) begin
          wait_nxt       = 1'b0;
          res_nxt[cnt_r] = sat60(sres);
          cnt_nxt        = cnt_r + 4'd1;
          if (cnt_r == D_P5) begin
            state_nxt = ST_DLAT;
          end
        end
      end
      ST_DLAT: begin
        for (int i = 0; i < 6; i++) begin
          k_nxt[i] = (mt_r == '0) ? sw_t'(0) : sat60(dv[i]);
          unique case (stg_r)
            2'd0: ks_nxt[i] = sl_t'(k_nxt[i]);
            2'd3: ks_nxt[i] = ks_r[i] + sl_t'(k_nxt[i]);
            default: ks_nxt[i] = ks_r[i] + (sl_t'(k_nxt[i]) <<< 1);
          endcase
        end
        cnt_nxt   = '0;
        state_nxt = ST_UPD;
      end
      ST_UPD: begin
        if (md_rsp.done) begin
          wait_nxt = 1'b0;
          if (stg_r == 2'd3) begin
            if (nv < 0) begin
              mass_nxt[cnt_r[2:0]] = '0;
            end else if (64'(nv) > MASS_MAX) begin
              mass_nxt[cnt_r[2:0]] = MASS_WIDTH'(MASS_MAX);
            end else begin
              mass_nxt[cnt_r[2:0]] = MASS_WIDTH'(nv);
            end
          end else begin
            y_nxt[cnt_r[2:0]] = sat60(nv);
          end
          cnt_nxt = cnt_r + 4'd1;
          if (cnt_r == 4'd5) begin
            cnt_nxt = '0;
            if (stg_r == 2'd3) begin
              tot_nxt   = '0;
              state_nxt = ST_TOT;
            end else begin
              stg_nxt   = stg_r + 2'd1;
              mt_nxt    = '0;
              state_nxt = ST_MT;
            end
          end
        end
      end
      ST_TOT: begin
        tot_nxt = tot_r + TOT_W'(mass_r[cnt_r[2:0]]);
        cnt_nxt = cnt_r + 4'd1;
        if (cnt_r == 4'd5) begin
          cnt_nxt = '0;
          // An empty tank reports zero flows.
          state_nxt = (tot_nxt == '0) ? ST_OUT : ST_FOP;
        end
      end
      ST_FOP: begin
        if (md_rsp.done) begin
          wait_nxt            = 1'b0;
          fin_nxt[cnt_r[1:0]] = md_rsp.q;
          cnt_nxt             = cnt_r + 4'd1;
          if (cnt_r[1:0] == F_WF) begin
            state_nxt = ST_OUT;
          end
        end
      end
      ST_OUT: begin
        if (out_ready) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      wait_r  <= 1'b0;
      cnt_r   <= '0;
      stg_r   <= '0;
      coef1_r <= '0;
      coef2_r <= '0;
      coef3_r <= '0;
      feeda_r <= '0;
      feedb_r <= '0;
      draw_r  <= '0;
      purge_r <= '0;
      for (int i = 0; i < 6; i++) begin
        mass_r[i] <= '0;
      end
    end else begin
      state_r <= state_nxt;
      wait_r  <= wait_nxt;
      cnt_r   <= cnt_nxt;
      stg_r   <= stg_nxt;
      mass_r  <= mass_nxt;
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_RATE1: coef1_r <= cfg_wdata;
          CFG_RATE2: coef2_r <= cfg_wdata;
          CFG_RATE3: coef3_r <= cfg_wdata;
          CFG_FEEDA: feeda_r <= cfg_wdata;
          CFG_FEEDB: feedb_r <= cfg_wdata;
          CFG_DRAW:  draw_r  <= cfg_wdata;
          CFG_PURGE: purge_r <= cfg_wdata[16:0];
          default: ;
        endcase
      end
    end
    y_r   <= y_nxt;
    k_r   <= k_nxt;
    ks_r  <= ks_nxt;
    res_r <= res_nxt;
    fin_r <= fin_nxt;
    mt_r  <= mt_nxt;
    tot_r <= tot_nxt;
    em_r  <= em_nxt;
    rm_r  <= rm_nxt;
    h_r   <= h_nxt;
  end

  sl_t         pf;
  logic [63:0] tot64;

  always_comb begin
    pf    = sl_t'(fin_r[F_FTP]) - sl_t'(fin_r[F_TEN]);
    tot64 = 64'(tot_r);
    if (pf > sl_t'(32'sh7FFF_FFFF)) begin
      out_product_flow = 32'sh7FFF_FFFF;
    end else if (pf < -sl_t'(64'h8000_0000)) begin
      out_product_flow = 32'sh8000_0000;
    end else begin
      out_product_flow = 32'(pf);
    end
  end

  assign in_ready       = (state_r == ST_IDLE);
  assign out_valid      = (state_r == ST_OUT);
  assign out_mass_a     = 32'(64'(mass_r[0]));
  assign out_mass_b     = 32'(64'(mass_r[1]));
  assign out_mass_c     = 32'(64'(mass_r[2]));
  assign out_mass_e     = 32'(64'(mass_r[3]));
  assign out_mass_p     = 32'(64'(mass_r[4]));
  assign out_mass_g     = 32'(64'(mass_r[5]));
  assign out_total_mass = tot64[34:0];
  assign out_waste_flow = fin_r[F_WF][31:0];

  a_ready_excl: assert property (@(posedge clk) disable iff (!rst_n)
    in_ready |-> !out_valid) else $error("input ready while a result is pending");
  a_upd_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_UPD |-> cnt_r < 4'd6) else $error("species counter out of range");
  a_dlat_src: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_DLAT |-> $past(state_r == ST_DOP || state_r == ST_MT))
    else $error("derivative latched without evaluation");
  a_done_wait: assert property (@(posedge clk) disable iff (!rst_n)
    md_rsp.done |-> wait_r) else $error("unit finished an operation not issued");

endmodule

[tb/reactor_plant_rk4_step_tb.sv]
`timescale 1ns / 100ps

module reactor_plant_rk4_step_tb;
  import rkp_pkg::*;

  localparam bit FN_STEP = 1'b0;
  localparam bit FN_LOAD = 1'b1;
  localparam logic [2:0] SP_A = 3'd0;
  localparam logic [2:0] SP_B = 3'd1;
  localparam logic [2:0] SP_C = 3'd2;
  localparam logic [2:0] SP_E = 3'd3;
  localparam logic [2:0] SP_P = 3'd4;
  localparam logic [2:0] SP_G = 3'd5;
  localparam logic [2:0] SP_BAD6 = 3'd6;
  localparam logic [2:0] SP_BAD7 = 3'd7;
  localparam longint unsigned CAP = (64'd1 << 58) - 64'd1;
  localparam longint unsigned MASS_TOP = 64'hFFFF_FFFF;
  localparam longint unsigned HOUR = 64'd1 << 32;
  localparam longint unsigned PURGE_FULL = 64'd65536;
  localparam int PHASES = 8;
  localparam int PHASE_ITEMS = 154;

  typedef longint vec_t[6];

  typedef struct {
    logic [31:0]        mass[6];
    logic [34:0]        total;
    logic signed [31:0] pflow;
    logic [31:0]        wflow;
  } plant_out_t;

  typedef struct {
    bit          func;
    logic [2:0]  sel;
    logic [31:0] load;
    logic [31:0] hours;
    bit          known;
    logic [34:0] total;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [2:0] cfg_index = '0;
  logic [31:0] cfg_wdata = '0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic in_func = 1'b0;
  logic [2:0] in_species_sel = '0;
  logic [31:0] in_load_mass = '0;
  logic [31:0] in_step_hours = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [31:0] out_mass_a, out_mass_b, out_mass_c, out_mass_e, out_mass_p, out_mass_g;
  logic [34:0] out_total_mass;
  logic signed [31:0] out_product_flow;
  logic [31:0] out_waste_flow;

  // Plant copy: configuration and masses.
  longint unsigned k_one, k_two, k_three, feed_a, feed_b, draw, purge;
  longint unsigned plant_mass[6];

  plant_out_t pending_q[$];
  bit known_q[$];
  logic [34:0] known_total_q[$];
  int errors = 0;
  int words_sent = 0;
  int words_checked = 0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;

  reactor_plant_rk4_step i_dut (.*);

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  initial begin
    #200_000_000;
    $display("Timeout waiting for results");
    $display("Mismatches found");
    $finish;
  end

  function automatic longint unsigned scale_div(longint unsigned a, longint unsigned b,
                                                longint unsigned d);
    logic [127:0] prod;
    logic [127:0] quo;
    if (d == 0) return CAP;
    prod = {64'd0, a} * {64'd0, b};
    quo = prod / {64'd0, d};
    if (quo > {64'd0, CAP}) return CAP;
    return quo[63:0];
  endfunction

  function automatic longint clip(longint x);
    if (x > longint'(CAP)) return longint'(CAP);
    if (x < -longint'(CAP)) return -longint'(CAP);
    return x;
  endfunction

  function automatic longint unsigned absval(longint x);
    return (x < 0) ? longint'(-x) : x;
  endfunction

  function automatic longint sscale_div(longint x, longint unsigned b, longint unsigned d);
    longint unsigned q;
    q = scale_div(absval(x), b, d);
    return (x < 0) ? -longint'(q) : longint'(q);
  endfunction

  function automatic longint halve(longint x);
    return (x < 0) ? -longint'(absval(x) >> 1) : (x >>> 1);
  endfunction

  function automatic longint reaction_rate(longint unsigned k, longint x, longint y,
                                           longint unsigned mt);
    longint unsigned t;
    longint unsigned r;
    t = scale_div(absval(x), absval(y), mt);
    r = scale_div(k, t, 64'd65536);
    return ((x < 0) != (y < 0)) ? -longint'(r) : longint'(r);
  endfunction

  function automatic void balance(input vec_t y, output vec_t dv);
    longint unsigned mt, eta, em, rm;
    longint r1, r2, r3;
    mt = 0;
    foreach (y[i]) if (y[i] > 0) mt += y[i];
    if (mt == 0) begin
      foreach (dv[i]) dv[i] = 0;
      return;
    end
    eta = (purge > PURGE_FULL) ? PURGE_FULL : purge;
    em = scale_div(eta, draw, PURGE_FULL);
    rm = draw - em;
    r1 = reaction_rate(k_one, y[0], y[1], mt);
    r2 = reaction_rate(k_two, y[1], y[2], mt);
    r3 = reaction_rate(k_three, y[2], y[4], mt);
    dv[0] = clip(longint'(feed_a) - sscale_div(y[0], em, mt) - r1);
    dv[1] = clip(longint'(feed_b) - sscale_div(y[1], em, mt) - r1 - r2);
    dv[2] = clip(-sscale_div(y[2], em, mt) + 2 * r1 - 2 * r2 - r3);
    dv[3] = clip(-sscale_div(y[3], em, mt) + 2 * r2);
    dv[4] = clip(sscale_div(y[3], rm, mt) / 10 - sscale_div(y[4], draw, mt) + r2 - halve(r3));
    dv[5] = clip(-sscale_div(y[5], draw, mt) + r3 + halve(r3));
  endfunction

  function automatic void integrate(longint unsigned h);
    vec_t m0, y, s1, s2, s3, s4;
    longint acc, nv;
    foreach (m0[i]) m0[i] = plant_mass[i];
    balance(m0, s1);
    foreach (y[i]) y[i] = clip(m0[i] + sscale_div(s1[i], h, 2 * HOUR));
    balance(y, s2);
    foreach (y[i]) y[i] = clip(m0[i] + sscale_div(s2[i], h, 2 * HOUR));
    balance(y, s3);
    foreach (y[i]) y[i] = clip(m0[i] + sscale_div(s3[i], h, HOUR));
    balance(y, s4);
    foreach (m0[i]) begin
      acc = s1[i] + 2 * s2[i] + 2 * s3[i] + s4[i];
      nv = m0[i] + sscale_div(acc, h, 6 * HOUR);
      if (nv < 0) nv = 0;
      plant_mass[i] = (nv > longint'(MASS_TOP)) ? MASS_TOP : nv;
    end
  endfunction

  function automatic plant_out_t plant_word(bit func, logic [2:0] sel, logic [31:0] load,
                                            logic [31:0] hours);
    plant_out_t r;
    longint unsigned tot, ftp, fte;
    longint pf;
    if (func == FN_LOAD) begin
      if (sel <= SP_G) plant_mass[sel] = load;
    end else begin
      integrate(hours);
    end
    tot = 0;
    pf = 0;
    r.wflow = '0;
    foreach (plant_mass[i]) tot += plant_mass[i];
    if (tot != 0) begin
      ftp = scale_div(draw, plant_mass[4], tot);
      fte = scale_div(draw, plant_mass[3], tot);
      pf = longint'(ftp) - longint'(fte) / 10;
      r.wflow = scale_div(draw, plant_mass[5], tot);
    end
    if (pf > 64'sd2147483647) pf = 64'sd2147483647;
    if (pf < -64'sd2147483648) pf = -64'sd2147483648;
    foreach (plant_mass[i]) r.mass[i] = plant_mass[i];
    r.total = tot;
    r.pflow = pf;
    return r;
  endfunction

  task automatic report(string what, longint unsigned got, longint unsigned want);
    errors++;
    $display("%0t: word %0d %s got %0h expected %0h", $time, words_checked, what, got, want);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [31:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    case (idx)
      CFG_RATE1: k_one = val;
      CFG_RATE2: k_two = val;
      CFG_RATE3: k_three = val;
      CFG_FEEDA: feed_a = val;
      CFG_FEEDB: feed_b = val;
      CFG_DRAW:  draw = val;
      CFG_PURGE: purge = val & 32'h1FFFF;
      default: ;
    endcase
    @(posedge clk);
  endtask

  task automatic send_word(bit func, logic [2:0] sel, logic [31:0] load, logic [31:0] hours,
                           bit known, logic [34:0] total);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_func <= func;
    in_species_sel <= sel;
    in_load_mass <= load;
    in_step_hours <= hours;
    do @(posedge clk); while (!in_ready);
    pending_q = {pending_q, plant_word(func, sel, load, hours)};
    known_q = {known_q, known};
    known_total_q = {known_total_q, total};
    words_sent++;
  endtask

  function automatic logic [31:0] pick_value(bit wide);
    case ($urandom_range(5))
      0: return 32'd0;
      1: return 32'hFFFF_FFFF;
      2: return wide ? $urandom : $urandom_range(32'h0004_0000);
      default: return $urandom_range(32'h0010_0000);
    endcase
  endfunction

  // Results are taken on the receiver side with random back-pressure.
  always @(posedge clk) begin
    plant_out_t want;
    bit known;
    logic [34:0] ktot;
    logic [31:0] got_mass[6];
    if (rst_n) begin
      out_ready <= ($urandom_range(99) >= recv_stall_pct);
      if (out_valid && out_ready) begin
        words_checked++;
        got_mass = '{out_mass_a, out_mass_b, out_mass_c, out_mass_e, out_mass_p, out_mass_g};
        if (pending_q.size() == 0) begin
          report("unexpected word", out_total_mass, 0);
        end else begin
          want = pending_q.pop_front();
          known = known_q.pop_front();
          ktot = known_total_q.pop_front();
          foreach (got_mass[i])
            if (got_mass[i] !== want.mass[i]) report($sformatf("mass[%0d]", i), got_mass[i],
                                                     want.mass[i]);
          if (out_total_mass !== want.total) report("total_mass", out_total_mass, want.total);
          if (known && out_total_mass !== ktot) report("total_mass (table)", out_total_mass, ktot);
          if (out_product_flow !== want.pflow)
            report("product_flow", 32'(out_product_flow), 32'(want.pflow));
          if (out_waste_flow !== want.wflow) report("waste_flow", out_waste_flow, want.wflow);
        end
      end
    end
  end

  stim_row_t rows[] = '{
    '{FN_STEP, SP_A, 32'd0, 32'd0, 1'b1, 35'd0},
    '{FN_STEP, SP_A, 32'd0, 32'hFFFF_FFFF, 1'b1, 35'd0},
    '{FN_LOAD, SP_BAD7, 32'hFFFF_FFFF, 32'd0, 1'b1, 35'd0},
    '{FN_LOAD, SP_A, 32'hFFFF_FFFF, 32'd0, 1'b1, 35'h0_FFFF_FFFF},
    '{FN_LOAD, SP_B, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 35'h1_FFFF_FFFE},
    '{FN_LOAD, SP_C, 32'hFFFF_FFFF, 32'd0, 1'b1, 35'h2_FFFF_FFFD},
    '{FN_LOAD, SP_E, 32'hFFFF_FFFF, 32'd0, 1'b1, 35'h3_FFFF_FFFC},
    '{FN_LOAD, SP_P, 32'hFFFF_FFFF, 32'd0, 1'b1, 35'h4_FFFF_FFFB},
    '{FN_LOAD, SP_G, 32'hFFFF_FFFF, 32'd0, 1'b1, 35'h5_FFFF_FFFA},
    '{FN_LOAD, SP_BAD6, 32'd0, 32'd0, 1'b1, 35'h5_FFFF_FFFA},
    '{FN_STEP, SP_BAD7, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 35'h5_FFFF_FFFA},
    '{FN_LOAD, SP_A, 32'd0, 32'd0, 1'b1, 35'h4_FFFF_FFFB},
    '{FN_LOAD, SP_G, 32'd0, 32'd0, 1'b1, 35'h3_FFFF_FFFC},
    '{FN_LOAD, SP_C, 32'h0001_0000, 32'd0, 1'b0, 35'd0},
    '{FN_STEP, SP_A, 32'd0, 32'h8000_0000, 1'b0, 35'd0},
    '{FN_STEP, SP_A, 32'd0, 32'h0000_0001, 1'b0, 35'd0}
  };

  initial begin
    logic [31:0] reg_val[7];
    k_one = 0; k_two = 0; k_three = 0; feed_a = 0; feed_b = 0; draw = 0; purge = 0;
    foreach (plant_mass[i]) plant_mass[i] = 0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (rows[i])
      send_word(rows[i].func, rows[i].sel, rows[i].load, rows[i].hours, rows[i].known,
                rows[i].total);

    for (int ph = 0; ph < PHASES; ph++) begin
      in_valid <= 1'b0;
      while (pending_q.size() != 0) @(posedge clk);
      case (ph % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 78; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 78; end
        default: begin send_idle_pct = 19; recv_stall_pct = 19; end
      endcase
      // First phase runs every register at its top, the second at zero
      // with full purge, the rest at random settings.
      for (int r = 0; r < 7; r++) begin
        if (ph == 0) reg_val[r] = (r == CFG_PURGE) ? 32'h1FFFF : 32'hFFFF_FFFF;
        else if (ph == 1) reg_val[r] = (r == CFG_PURGE) ? 32'h10000 : 32'd0;
        else if (r == CFG_PURGE) reg_val[r] = $urandom_range(32'h1FFFF);
        else reg_val[r] = pick_value(ph > 5);
      end
      for (int r = 0; r < 7; r++) write_reg(r[2:0], reg_val[r]);
      cfg_we <= 1'b0;
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if ($urandom_range(99) < 45) begin
          send_word(FN_STEP, 3'($urandom), $urandom,
                    ($urandom_range(9) == 0) ? $urandom : $urandom_range(32'h0100_0000),
                    1'b0, '0);
        end else begin
          send_word(FN_LOAD, ($urandom_range(9) == 0) ? 3'($urandom) : 3'($urandom_range(5)),
                    pick_value(1'b1), $urandom, 1'b0, '0);
        end
      end
    end
    in_valid <= 1'b0;
    while (pending_q.size() != 0) @(posedge clk);
    repeat (6000) @(posedge clk);
    $display("Sent %0d step and load words over %0d register settings, checked %0d results.",
             words_sent, PHASES + 1, words_checked);
    if (errors == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
